// ===== sv/ham_pkg.sv =====
// ham_pkg: types, sizes and codes shared by the handle array manager.
// No dependencies; the design files that use it refer to it by scoped names, the testbench files import it.
package ham_pkg;

    // sizing
    localparam int NUM_HANDLES = 16;
    localparam int MAX_LENGTH  = 64;
    localparam int WORD_BITS   = 64;

    localparam int HANDLE_BITS = $clog2(NUM_HANDLES);
    localparam int COUNT_BITS  = $clog2(NUM_HANDLES + 1);
    localparam int LEN_BITS    = $clog2(MAX_LENGTH + 1);
    localparam int STORE_DEPTH = NUM_HANDLES * MAX_LENGTH;
    localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SMALL_BITS  = (HANDLE_BITS > LEN_BITS) ? HANDLE_BITS : LEN_BITS;

    // fixed field widths of the ports
    localparam int OP_BITS     = 3;
    localparam int ID_BITS     = 4;
    localparam int IDX_BITS    = 6;
    localparam int DATA_BITS   = 64;
    localparam int STATUS_BITS = 3;

    // operations
    localparam logic [OP_BITS-1:0] OP_NEW    = 3'd0;
    localparam logic [OP_BITS-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_BITS-1:0] OP_APPEND = 3'd2;
    localparam logic [OP_BITS-1:0] OP_POP    = 3'd3;
    localparam logic [OP_BITS-1:0] OP_SET    = 3'd4;
    localparam logic [OP_BITS-1:0] OP_GET    = 3'd5;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd6;
    localparam logic [OP_BITS-1:0] OP_LENGTH = 3'd7;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD_HANDLE = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_BAD_INDEX  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_POP_EMPTY  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_NO_HANDLE  = 3'd5;

    typedef struct packed {
        logic [OP_BITS-1:0]   req_type;
        logic [ID_BITS-1:0]   array_id;
        logic [IDX_BITS-1:0]  elem_index;
        logic [DATA_BITS-1:0] data_word;
    } ham_req_t;

    typedef struct packed {
        logic [DATA_BITS-1:0]   result_word;
        logic [STATUS_BITS-1:0] status;
    } ham_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic exec;      // decode, update state, issue store access
    } ham_cmd_t;

endpackage

// ===== sv/ham_ram.sv =====
// ham_ram: generic single-port RAM, one write or read per cycle, registered read.
// No dependencies.
module ham_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== sv/ham_ctrl.sv =====
// ham_ctrl: sequencing FSM of the handle array manager.
// Depends on ham_pkg for the command struct.
module ham_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output ham_pkg::ham_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // a new word may enter during the result cycle
    assign busy   = (state_reg == S_EXEC);
    assign accept = start && !busy;
    assign done   = (state_reg == S_RESP);

    assign cmd.capture = accept;
    assign cmd.exec    = (state_reg == S_EXEC);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_RESP;
            S_RESP:  state_next = accept ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/ham_dp.sv =====
// ham_dp: handle tables, freed-handle FIFO, element store and result register.
// Depends on ham_pkg and ham_ram.
module ham_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  ham_pkg::ham_cmd_t cmd,
    input  ham_pkg::ham_req_t req,
    output ham_pkg::ham_rsp_t rsp
);

    localparam int HB = ham_pkg::HANDLE_BITS;
    localparam int CB = ham_pkg::COUNT_BITS;
    localparam int LB = ham_pkg::LEN_BITS;
    localparam int AB = ham_pkg::ADDR_BITS;
    localparam int SB = ham_pkg::SMALL_BITS;
    localparam int WB = ham_pkg::WORD_BITS;
    localparam int NH = ham_pkg::NUM_HANDLES;

    ham_pkg::ham_req_t req_reg;

    logic          valid_reg  [NH];
    logic [LB-1:0] length_reg [NH];
    logic [HB-1:0] fifo_reg   [NH];
    logic [HB-1:0] head_reg;
    logic [HB-1:0] tail_reg;
    logic [CB-1:0] count_reg;
    logic [CB-1:0] fresh_reg;

    logic [SB-1:0]                   res_reg;
    logic [ham_pkg::STATUS_BITS-1:0] st_reg;
    logic                            use_ram_reg;

    // decode results
    logic                            id_ok;
    logic [HB-1:0]                   h;
    logic                            h_live;
    logic [LB-1:0]                   len;
    logic [HB-1:0]                   new_h;
    logic [SB-1:0]                   res;
    logic [ham_pkg::STATUS_BITS-1:0] st;
    logic                            use_ram;
    logic                            take_fifo;
    logic                            take_fresh;
    logic                            push_fifo;
    logic                            len_we;
    logic [HB-1:0]                   len_h;
    logic [LB-1:0]                   len_val;
    logic                            valid_we;
    logic                            valid_val;
    logic                            elem_we;
    logic [LB-1:0]                   elem_off;
    logic [AB-1:0]                   slot;
    logic [WB-1:0]                   ram_rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
    end

    assign id_ok  = (32'(req_reg.array_id) < NH);
    assign h      = HB'(req_reg.array_id);
    assign h_live = id_ok && valid_reg[h];
    assign len    = length_reg[h];
    assign new_h  = (count_reg != '0) ? fifo_reg[head_reg] : HB'(fresh_reg);

    always_comb
    begin
        res        = '0;
        st         = ham_pkg::ST_OK;
        use_ram    = 1'b0;
        take_fifo  = 1'b0;
        take_fresh = 1'b0;
        push_fifo  = 1'b0;
        len_we     = 1'b0;
        len_h      = h;
        len_val    = '0;
        valid_we   = 1'b0;
        valid_val  = 1'b0;
        elem_we    = 1'b0;
        elem_off   = LB'(req_reg.elem_index);
        if (req_reg.req_type == ham_pkg::OP_NEW)
        begin
            if (count_reg != '0 || 32'(fresh_reg) < NH)
            begin
                take_fifo  = (count_reg != '0);
                take_fresh = (count_reg == '0);
                len_we     = 1'b1;
                len_h      = new_h;
                valid_we   = 1'b1;
                valid_val  = 1'b1;
                res        = SB'(new_h);
            end
            else
            begin
                st = ham_pkg::ST_NO_HANDLE;
            end
        end
        else if (!h_live)
        begin
            st = ham_pkg::ST_BAD_HANDLE;
        end
        else
        begin
            unique case (req_reg.req_type) inside
                ham_pkg::OP_DELETE:
                begin
                    valid_we  = 1'b1;
                    len_we    = 1'b1;
                    push_fifo = 1'b1;
                end
                ham_pkg::OP_APPEND:
                begin
                    if (32'(len) >= ham_pkg::MAX_LENGTH)
                    begin
                        st = ham_pkg::ST_FULL;
                    end
                    else
                    begin
                        elem_off = len;
                        elem_we  = 1'b1;
                        len_we   = 1'b1;
                        len_val  = len + LB'(1);
                    end
                end
                ham_pkg::OP_POP:
                begin
                    if (len == '0)
                    begin
                        st = ham_pkg::ST_POP_EMPTY;
                    end
                    else
                    begin
                        elem_off = len - LB'(1);
                        use_ram  = 1'b1;
                        len_we   = 1'b1;
                        len_val  = len - LB'(1);
                    end
                end
                ham_pkg::OP_SET, ham_pkg::OP_GET:
                begin
                    if (32'(req_reg.elem_index) >= 32'(len))
                    begin
                        st = ham_pkg::ST_BAD_INDEX;
                    end
                    else if (req_reg.req_type == ham_pkg::OP_SET)
                    begin
                        elem_we = 1'b1;
                    end
                    else
                    begin
                        use_ram = 1'b1;
                    end
                end
                ham_pkg::OP_CLEAR:
                begin
                    len_we = 1'b1;
                end
                ham_pkg::OP_LENGTH:
                begin
                    res = SB'(len);
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    assign slot = AB'(h) * AB'(ham_pkg::MAX_LENGTH) + AB'(elem_off);

    ham_ram #(
        .WIDTH (WB),
        .DEPTH (ham_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.exec && elem_we),
        .addr  (slot),
        .wdata (req_reg.data_word[WB-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NH; i++)
            begin
                valid_reg[i]  <= 1'b0;
                length_reg[i] <= '0;
            end
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
        end
        else if (cmd.exec)
        begin
            if (valid_we)
            begin
                valid_reg[len_h] <= valid_val;
            end
            if (len_we)
            begin
                length_reg[len_h] <= len_val;
            end
            if (take_fifo)
            begin
                head_reg  <= (32'(head_reg) == NH - 1) ? '0 : head_reg + HB'(1);
                count_reg <= count_reg - CB'(1);
            end
            if (take_fresh)
            begin
                fresh_reg <= fresh_reg + CB'(1);
            end
            if (push_fifo)
            begin
                tail_reg  <= (32'(tail_reg) == NH - 1) ? '0 : tail_reg + HB'(1);
                count_reg <= count_reg + CB'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && push_fifo)
        begin
            fifo_reg[tail_reg] <= h;
        end
        if (cmd.exec)
        begin
            res_reg     <= res;
            st_reg      <= st;
            use_ram_reg <= use_ram;
        end
    end

    // store data arrives in the result cycle
    assign rsp.result_word = use_ram_reg ? ham_pkg::DATA_BITS'(ram_rdata)
                                         : ham_pkg::DATA_BITS'(res_reg);
    assign rsp.status      = st_reg;

endmodule

// ===== sv/handle_array_manager_core.sv =====
// handle_array_manager_core: top level of the handle array manager.
// Depends on ham_pkg, ham_ctrl, ham_dp and ham_ram.
//
// Usage:
//   A request word (req: operation, handle, element index, data word) is
//   taken at a rising edge where start is high and busy is low.
//   Every request gives exactly one response word on rsp, marked by done
//   for one cycle; it must be taken then, the receiver cannot stall it.
//   The accepting edge enters the execute state, which is always followed
//   by the response state with done high. busy is high only in the
//   execute cycle, where the handle tables are read and updated and the
//   single port of the element store is accessed; the next request may be
//   accepted while the previous response is shown.
//   Errors (bad handle, index out of range, pop empty, array full, no free
//   handle) return a nonzero status, a zero result and leave state as is.
//   Reset: rst_n (async, active low) invalidates all handles, zeroes all
//   lengths and the handle counters; no clearing pass, the element store
//   is not cleared and is only read below an array's length.
module handle_array_manager_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ham_pkg::ham_req_t req,
    output logic              done,
    output ham_pkg::ham_rsp_t rsp
);

    ham_pkg::ham_cmd_t cmd;

    ham_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    ham_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

`ifndef SYNTHESIS
    // execute is always followed by exactly one response cycle
    a_exec_then_done : assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("execute cycle not followed by response");

    a_done_after_exec : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("response without execute cycle");

    a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
        !(busy && done))
        else $error("busy and done together");

    // failed requests carry a zero result
    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ham_pkg::ST_OK) |-> (rsp.result_word == '0))
        else $error("error response with nonzero result");
`endif

endmodule

// ===== tb/sv/ham_pool_checker.sv =====
// ham_pool_checker: watches the request and response words of the handle array
// manager, keeps a shadow of the handle pool and compares every response.
// Depends on ham_pkg.
module ham_pool_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  ham_pkg::ham_req_t req,
    input  logic              done,
    input  ham_pkg::ham_rsp_t rsp,
    output int                mismatches,
    output int                outstanding,
    output int                checked
);
    import ham_pkg::*;

    localparam logic [DATA_BITS-1:0] WORD_MASK =
        (WORD_BITS >= 64) ? {DATA_BITS{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);

    // shadow of the pool
    logic                   valid_tab [NUM_HANDLES];
    logic [LEN_BITS-1:0]    len_tab   [NUM_HANDLES];
    logic [DATA_BITS-1:0]   elem_mem  [STORE_DEPTH];
    logic [COUNT_BITS-1:0]  fresh_count;
    logic [HANDLE_BITS-1:0] freed_fifo [NUM_HANDLES];
    logic [HANDLE_BITS-1:0] freed_head;
    logic [HANDLE_BITS-1:0] freed_tail;
    logic [COUNT_BITS-1:0]  freed_count;

    ham_rsp_t pending_rsp [$];

    task automatic clear_pool();
        for (int i = 0; i < NUM_HANDLES; i++)
        begin
            valid_tab[i] = 1'b0;
            len_tab[i]   = '0;
        end
        fresh_count = '0;
        freed_head  = '0;
        freed_tail  = '0;
        freed_count = '0;
    endtask

    task automatic predict_pool_op(input ham_req_t r, output ham_rsp_t e);
        logic [HANDLE_BITS-1:0] h;
        logic [LEN_BITS-1:0]    len;
        logic [DATA_BITS-1:0]   word;
        int                     base;
        e.result_word = '0;
        e.status      = ST_OK;
        word          = r.data_word & WORD_MASK;
        h             = '0;
        if (r.req_type == OP_NEW)
        begin
            // recycled handles go out before fresh ones
            if (freed_count != 0)
            begin
                h           = freed_fifo[freed_head];
                freed_head  = freed_head + 1'b1;
                freed_count = freed_count - 1'b1;
            end
            else if (fresh_count < NUM_HANDLES)
            begin
                h           = fresh_count[HANDLE_BITS-1:0];
                fresh_count = fresh_count + 1'b1;
            end
            else
            begin
                e.status = ST_NO_HANDLE;
            end
            if (e.status == ST_OK)
            begin
                valid_tab[h]  = 1'b1;
                len_tab[h]    = '0;
                e.result_word = DATA_BITS'(h);
            end
        end
        else if (int'(r.array_id) >= NUM_HANDLES || !valid_tab[r.array_id])
        begin
            e.status = ST_BAD_HANDLE;
        end
        else
        begin
            h    = r.array_id[HANDLE_BITS-1:0];
            len  = len_tab[h];
            base = int'(h) * MAX_LENGTH;
            case (r.req_type)
                OP_DELETE:
                begin
                    valid_tab[h]           = 1'b0;
                    len_tab[h]             = '0;
                    freed_fifo[freed_tail] = h;
                    freed_tail             = freed_tail + 1'b1;
                    freed_count            = freed_count + 1'b1;
                end
                OP_APPEND:
                begin
                    if (len >= MAX_LENGTH)
                        e.status = ST_FULL;
                    else
                    begin
                        elem_mem[base + int'(len)] = word;
                        len_tab[h] = len + 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (len == 0)
                        e.status = ST_POP_EMPTY;
                    else
                    begin
                        e.result_word = elem_mem[base + int'(len) - 1];
                        len_tab[h]    = len - 1'b1;
                    end
                end
                OP_SET:
                begin
                    if (r.elem_index >= len)
                        e.status = ST_BAD_INDEX;
                    else
                        elem_mem[base + int'(r.elem_index)] = word;
                end
                OP_GET:
                begin
                    if (r.elem_index >= len)
                        e.status = ST_BAD_INDEX;
                    else
                        e.result_word = elem_mem[base + int'(r.elem_index)];
                end
                OP_CLEAR:
                begin
                    len_tab[h] = '0;
                end
                default:
                begin
                    e.result_word = DATA_BITS'(len);
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ham_rsp_t want;
        if (!rst_n)
        begin
            clear_pool();
            pending_rsp.delete();
            mismatches  = 0;
            outstanding = 0;
            checked     = 0;
        end
        else
        begin
            // the response of an older word can show in the cycle a new word is taken
            if (done)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response word: exp none got %h/%0d",
                             $time, rsp.result_word, rsp.status);
                    mismatches++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    checked++;
                    if (rsp.result_word !== want.result_word)
                    begin
                        $display("%0t: result_word mismatch: exp %h got %h",
                                 $time, want.result_word, rsp.result_word);
                        mismatches++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch: exp %0d got %0d",
                                 $time, want.status, rsp.status);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_pool_op(req, want);
                pending_rsp.insert(pending_rsp.size(), want);
            end
            outstanding = pending_rsp.size();
        end
    end

endmodule

// ===== tb/sv/handle_array_manager_core_tb.sv =====
// handle_array_manager_core_tb: drives directed and random request words into
// the handle array manager; ham_pool_checker does the checking.
// Depends on ham_pkg, handle_array_manager_core and ham_pool_checker.
module handle_array_manager_core_tb;
    import ham_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 400;
    localparam int REQ_BITS     = $bits(ham_req_t);

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ham_req_t req;
    logic     done;
    ham_rsp_t rsp;

    int mismatches;
    int outstanding;
    int checked;
    int cycles;
    int words_sent;
    int no_gap_left;

    handle_array_manager_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    ham_pool_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [DATA_BITS-1:0] rand_data();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return {$urandom(), $urandom()};
    endfunction

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                             input logic [IDX_BITS-1:0] idx,
                             input logic [DATA_BITS-1:0] data);
        ham_req_t w;
        w.req_type   = op;
        w.array_id   = id;
        w.elem_index = idx;
        w.data_word  = data;
        start <= 1'b1;
        req   <= w;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        words_sent++;
        @(negedge clk);
    endtask

    // mostly back to back or short gaps, a few long ones, and gap-free stretches
    task automatic idle_gap();
        int n;
        int roll;
        n = 0;
        if (no_gap_left > 0)
            no_gap_left--;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                no_gap_left = $urandom_range(10, 30);
            else if (roll < 55)
                n = 0;
            else if (roll < 88)
                n = $urandom_range(1, 3);
            else
                n = $urandom_range(8, 25);
        end
        if (n > 0)
        begin
            start <= 1'b0;
            req   <= REQ_BITS'({$urandom(), $urandom(), $urandom()});
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_gap(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                            input logic [IDX_BITS-1:0] idx,
                            input logic [DATA_BITS-1:0] data);
        send_word(op, id, idx, data);
        idle_gap();
    endtask

    task automatic random_word();
        int                   roll;
        logic [OP_BITS-1:0]   op;
        logic [ID_BITS-1:0]   id;
        logic [IDX_BITS-1:0]  idx;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            op = OP_NEW;
        else if (roll < 16)
            op = OP_DELETE;
        else if (roll < 46)
            op = OP_APPEND;
        else if (roll < 56)
            op = OP_POP;
        else if (roll < 70)
            op = OP_SET;
        else if (roll < 86)
            op = OP_GET;
        else if (roll < 90)
            op = OP_CLEAR;
        else
            op = OP_LENGTH;
        id  = ID_BITS'($urandom_range(0, 15));
        // small indexes land inside the arrays most of the time
        idx = ($urandom_range(0, 9) < 7) ? IDX_BITS'($urandom_range(0, 7))
                                         : IDX_BITS'($urandom_range(0, 63));
        send_gap(op, id, idx, rand_data());
    endtask

    initial
    begin
        logic [ID_BITS-1:0] fill_id;
        logic [DATA_BITS-1:0] pattern;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        words_sent  = 0;
        no_gap_left = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners: empty pool, bounds, pop empty, recycle, exhaustion
        pattern = 64'hA5A5_5A5A_0F0F_F0F0;
        send_gap(OP_NEW,    4'd0,  6'd0,  '0);
        send_gap(OP_APPEND, 4'd0,  6'd0,  '1);
        send_gap(OP_APPEND, 4'd0,  6'd0,  '0);
        send_gap(OP_LENGTH, 4'd0,  6'd0,  '0);
        send_gap(OP_GET,    4'd0,  6'd63, '0);
        send_gap(OP_SET,    4'd0,  6'd0,  pattern);
        send_gap(OP_GET,    4'd0,  6'd0,  '0);
        send_gap(OP_POP,    4'd0,  6'd0,  '0);
        send_gap(OP_POP,    4'd0,  6'd0,  '0);
        send_gap(OP_POP,    4'd0,  6'd0,  '0);
        send_gap(OP_APPEND, 4'd0,  6'd0,  ~pattern);
        send_gap(OP_CLEAR,  4'd0,  6'd0,  '0);
        send_gap(OP_DELETE, 4'd0,  6'd0,  '0);
        send_gap(OP_APPEND, 4'd0,  6'd0,  '1);
        send_gap(OP_GET,    4'd15, 6'd0,  '0);
        send_gap(OP_NEW,    4'd9,  6'd0,  '0);
        send_gap(OP_LENGTH, 4'd0,  6'd0,  '0);
        for (int i = 0; i < NUM_HANDLES; i++)
            send_gap(OP_NEW, 4'($urandom_range(0, 15)), 6'd0, '0);

        // random mix, with an occasional burst that runs one array past full
        while (words_sent < RANDOM_WORDS + 33)
        begin
            if ($urandom_range(0, 99) < 2)
            begin
                fill_id = ID_BITS'($urandom_range(0, 15));
                repeat (MAX_LENGTH + 2)
                    send_gap(OP_APPEND, fill_id, 6'($urandom_range(0, 63)), rand_data());
            end
            else
                random_word();
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        $display("covered %0d request words over all eight operations and every status,",
                 words_sent);
        $display("with random gaps and fill bursts; %0d response words compared", checked);
        if (mismatches == 0 && outstanding == 0)
            $display("[handle_array_manager_core] OK");
        else
            $display("[handle_array_manager_core] ERROR");
        $finish;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("[handle_array_manager_core] ERROR");
        $finish;
    end

endmodule
